// ===== rtl/pad_to_pointer_and_key_events_top_macros.svh =====
// Assertion macros for the pointer and key event block.
`ifndef PAD_TO_POINTER_AND_KEY_EVENTS_TOP_MACROS_SVH
`define PAD_TO_POINTER_AND_KEY_EVENTS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PTKE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define PTKE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ptke_pkg.sv =====
`timescale 1ns / 1ps

package ptke_pkg;

   localparam logic CMD_POLL = 1'b0;
   localparam logic CMD_WARP = 1'b1;

   typedef enum logic [1:0] {
      EV_KEY    = 2'd0,
      EV_DRAG   = 2'd1,
      EV_HOVER  = 2'd2,
      EV_BUTTON = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      REG_DEAD_ZONE     = 3'd0,
      REG_TRIGGER       = 3'd1,
      REG_SPEED         = 3'd2,
      REG_MAX_STEP      = 3'd3,
      REG_SCREEN_WIDTH  = 3'd4,
      REG_SCREEN_HEIGHT = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_SPEED,
      ST_MUL_TIME,
      ST_MUL_RECIP,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   localparam logic [7:0]  RST_DEAD_ZONE     = 8'd16;
   localparam logic [7:0]  RST_TRIGGER       = 8'd128;
   localparam logic [10:0] RST_SPEED         = 11'd500;
   localparam logic [9:0]  RST_MAX_STEP      = 10'd100;
   localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd640;
   localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd480;

   // Button bit positions.
   localparam int BTN_A     = 0;
   localparam int BTN_B     = 1;
   localparam int BTN_START = 2;
   localparam int BTN_LEFT  = 3;
   localparam int BTN_RIGHT = 4;
   localparam int BTN_UP    = 5;
   localparam int BTN_DOWN  = 6;

   // Listener bit positions.
   localparam int LIS_KEY    = 0;
   localparam int LIS_BUTTON = 1;
   localparam int LIS_DRAG   = 2;
   localparam int LIS_HOVER  = 3;

   // Virtual key indexes.
   localparam int KEY_LEFT   = 0;
   localparam int KEY_RIGHT  = 1;
   localparam int KEY_UP     = 2;
   localparam int KEY_DOWN   = 3;
   localparam int KEY_ENTER  = 4;
   localparam int KEY_ESCAPE = 5;
   localparam int KEY_PAUSE  = 6;
   localparam int NUM_KEYS   = 7;

   // Pending event slots, emitted lowest first.
   localparam int SLOT_MOTION = 0;
   localparam int SLOT_BUTTON = 1;
   localparam int SLOT_KEY0   = 2;
   localparam int NUM_SLOTS   = SLOT_KEY0 + NUM_KEYS;

   // Move scale: pixels = mag * speed * ms / (128 * 1000) = ... / (125 << 10).
   localparam int PROD_WIDTH     = 28;
   localparam int SCALE_SHIFT    = 10;
   localparam int RECIP_DIVISOR  = 125;
   localparam int RECIP_SHIFT    = 37;
   localparam int RECIP_WIDTH    = 31;
   localparam logic [RECIP_WIDTH-1:0] RECIP_MULT = 31'd1099511627;

   typedef struct packed {
      logic [7:0]  dead_zone;
      logic [7:0]  trigger_threshold;
      logic [10:0] pointer_speed;
      logic [9:0]  max_step_ms;
      logic [10:0] screen_width;
      logic [10:0] screen_height;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic stage_speed;
      logic stage_time;
      logic stage_recip;
      logic commit;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pending;
      logic last_event;
      logic out_free;
   } ctrl_status_type;

   // Largest pixel index for a screen size; zero acts as one, capped at 1023.
   function automatic logic [9:0] axis_max(input logic [10:0] size);
      logic [10:0] m;
      m = (size == 11'd0) ? 11'd0 : size - 11'd1;
      return (m > 11'd1023) ? 10'd1023 : m[9:0];
   endfunction

endpackage

// ===== rtl/ptke_csr.sv =====
`timescale 1ns / 1ps

module ptke_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output ptke_pkg::cfg_type cfg
);

   ptke_pkg::cfg_type cfg_ff;
   ptke_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              write;

   assign index  = paddr[4:2];
   assign write  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            ptke_pkg::REG_DEAD_ZONE:     cfg_in.dead_zone         = pwdata[7:0];
            ptke_pkg::REG_TRIGGER:       cfg_in.trigger_threshold = pwdata[7:0];
            ptke_pkg::REG_SPEED:         cfg_in.pointer_speed     = pwdata[10:0];
            ptke_pkg::REG_MAX_STEP:      cfg_in.max_step_ms       = pwdata[9:0];
            ptke_pkg::REG_SCREEN_WIDTH:  cfg_in.screen_width      = pwdata[10:0];
            ptke_pkg::REG_SCREEN_HEIGHT: cfg_in.screen_height     = pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ptke_pkg::REG_DEAD_ZONE:     prdata = {24'd0, cfg_ff.dead_zone};
         ptke_pkg::REG_TRIGGER:       prdata = {24'd0, cfg_ff.trigger_threshold};
         ptke_pkg::REG_SPEED:         prdata = {21'd0, cfg_ff.pointer_speed};
         ptke_pkg::REG_MAX_STEP:      prdata = {22'd0, cfg_ff.max_step_ms};
         ptke_pkg::REG_SCREEN_WIDTH:  prdata = {21'd0, cfg_ff.screen_width};
         ptke_pkg::REG_SCREEN_HEIGHT: prdata = {21'd0, cfg_ff.screen_height};
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone         <= ptke_pkg::RST_DEAD_ZONE;
         cfg_ff.trigger_threshold <= ptke_pkg::RST_TRIGGER;
         cfg_ff.pointer_speed     <= ptke_pkg::RST_SPEED;
         cfg_ff.max_step_ms       <= ptke_pkg::RST_MAX_STEP;
         cfg_ff.screen_width      <= ptke_pkg::RST_SCREEN_WIDTH;
         cfg_ff.screen_height     <= ptke_pkg::RST_SCREEN_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/ptke_axis.sv =====
`timescale 1ns / 1ps

module ptke_axis #(
   parameter int FRAC_BITS = 8
) (
   input  logic                   clock,
   input  ptke_pkg::ctrl_cmd_type cmd,
   input  logic [7:0]             mag,
   input  logic                   negative,
   input  logic [10:0]            speed,
   input  logic [9:0]             dt,
   input  logic [9+FRAC_BITS:0]   pos,
   input  logic [9+FRAC_BITS:0]   limit,
   output logic [9+FRAC_BITS:0]   next_pos
);

   localparam int PSW = 10 + FRAC_BITS;
   localparam int PW  = ptke_pkg::PROD_WIDTH;
   localparam int NW  = PW + FRAC_BITS - ptke_pkg::SCALE_SHIFT;
   localparam int RW  = ptke_pkg::RECIP_WIDTH;
   localparam int QW  = NW + RW - ptke_pkg::RECIP_SHIFT;
   localparam int SW  = QW + 2;

   logic [18:0]         speed_prod_ff;
   logic [PW-1:0]       time_prod_ff;
   logic [NW+RW-1:0]    recip_prod_ff;
   logic [28:0]         time_full;
   logic [PW+FRAC_BITS-1:0] scaled;
   logic [NW-1:0]       num;
   logic [NW+RW-1:0]    recip_full;
   logic [QW-1:0]       quot_est;
   logic [NW-1:0]       back;
   logic [NW-1:0]       rem;
   logic                corr;
   logic [QW-1:0]       delta;
   logic signed [SW-1:0] pos_s;
   logic signed [SW-1:0] delta_s;
   logic signed [SW-1:0] limit_s;
   logic signed [SW-1:0] sum_s;

   assign time_full  = {10'd0, speed_prod_ff} * {19'd0, dt};
   assign scaled     = {time_prod_ff, {FRAC_BITS{1'b0}}};
   assign num        = scaled[PW+FRAC_BITS-1:ptke_pkg::SCALE_SHIFT];
   assign recip_full = (NW+RW)'(num) * (NW+RW)'(ptke_pkg::RECIP_MULT);

   // Reciprocal estimate is low by at most one; fix with one compare.
   assign quot_est = recip_prod_ff[NW+RW-1:ptke_pkg::RECIP_SHIFT];
   assign back     = NW'(quot_est) * NW'(ptke_pkg::RECIP_DIVISOR);
   assign rem      = num - back;
   assign corr     = rem >= NW'(ptke_pkg::RECIP_DIVISOR);
   assign delta    = quot_est + {{(QW-1){1'b0}}, corr};

   assign pos_s   = signed'(SW'(pos));
   assign delta_s = signed'(SW'(delta));
   assign limit_s = signed'(SW'(limit));
   assign sum_s   = negative ? pos_s - delta_s : pos_s + delta_s;

   always_comb begin
      if (sum_s < 0) begin
         next_pos = '0;
      end else if (sum_s > limit_s) begin
         next_pos = limit;
      end else begin
         next_pos = sum_s[PSW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stage_speed) begin
         speed_prod_ff <= {11'd0, mag} * {8'd0, speed};
      end
      if (cmd.stage_time) begin
         time_prod_ff <= time_full[PW-1:0];
      end
      if (cmd.stage_recip) begin
         recip_prod_ff <= recip_full;
      end
   end

endmodule

// ===== rtl/ptke_dp.sv =====
`timescale 1ns / 1ps

module ptke_dp #(
   parameter int FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ptke_pkg::cfg_type         cfg,
   input  ptke_pkg::ctrl_cmd_type    cmd,
   output ptke_pkg::ctrl_status_type status,
   input  logic                      req_cmd,
   input  logic                      req_pad_present,
   input  logic [6:0]                req_button_bits,
   input  logic signed [7:0]         req_stick_x,
   input  logic signed [7:0]         req_stick_y,
   input  logic [7:0]                req_left_trigger,
   input  logic [15:0]               req_elapsed_ms,
   input  logic [3:0]                req_listener_bits,
   input  logic [9:0]                req_warp_x,
   input  logic [9:0]                req_warp_y,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_event_kind,
   output logic [2:0]                rsp_key_index,
   output logic                      rsp_released,
   output logic [9:0]                rsp_pointer_column,
   output logic [9:0]                rsp_pointer_row,
   output logic                      rsp_last
);

   localparam int PSW = 10 + FRAC_BITS;
   localparam int NS  = ptke_pkg::NUM_SLOTS;
   localparam int NK  = ptke_pkg::NUM_KEYS;

   logic [PSW-1:0] pointer_x_ff, pointer_x_in;
   logic [PSW-1:0] pointer_y_ff, pointer_y_in;
   logic           button_held_ff, button_held_in;
   logic [NK-1:0]  keys_held_ff, keys_held_in;
   logic [NS-1:0]  mask_ff, mask_in;
   logic           drag_ff;
   logic           button_rel_ff;
   logic           move_ff;
   logic [7:0]     mag_x_ff, mag_y_ff;
   logic           neg_x_ff, neg_y_ff;
   logic [9:0]     dt_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   ptke_pkg::event_kind_type rsp_kind_ff;
   logic [2:0]     rsp_key_ff;
   logic           rsp_rel_ff;
   logic [9:0]     rsp_col_ff;
   logic [9:0]     rsp_row_ff;
   logic           rsp_last_ff;

   logic [6:0]     btn;
   logic [7:0]     trig;
   logic [7:0]     abs_x, abs_y;
   logic           live_x, live_y;
   logic           move;
   logic [9:0]     dt;
   logic [NK-1:0]  keys_now;
   logic           pause;
   logic [NS-1:0]  mask_new;
   logic [PSW-1:0] limit_x, limit_y;
   logic [PSW-1:0] next_x, next_y;
   logic [3:0]     sel;
   logic [2:0]     key_sel;
   logic [NS-1:0]  mask_rest;
   ptke_pkg::event_kind_type ev_kind;
   logic [2:0]     ev_key;
   logic           ev_rel;

   assign btn   = req_pad_present ? req_button_bits : 7'd0;
   assign trig  = req_pad_present ? req_left_trigger : 8'd0;
   assign abs_x = req_stick_x[7] ? (~req_stick_x) + 8'd1 : req_stick_x;
   assign abs_y = req_stick_y[7] ? (~req_stick_y) + 8'd1 : req_stick_y;
   assign live_x = (req_stick_x != 8'sd0) && (abs_x >= cfg.dead_zone);
   assign live_y = (req_stick_y != 8'sd0) && (abs_y >= cfg.dead_zone);
   assign move  = req_pad_present && (|req_listener_bits[3:1]) && (live_x || live_y);
   assign dt    = (req_elapsed_ms < {6'd0, cfg.max_step_ms}) ? req_elapsed_ms[9:0]
                                                               : cfg.max_step_ms;
   assign pause = trig >= cfg.trigger_threshold;

   always_comb begin
      keys_now = '0;
      keys_now[ptke_pkg::KEY_LEFT]   = btn[ptke_pkg::BTN_LEFT];
      keys_now[ptke_pkg::KEY_RIGHT]  = btn[ptke_pkg::BTN_RIGHT];
      keys_now[ptke_pkg::KEY_UP]     = btn[ptke_pkg::BTN_UP];
      keys_now[ptke_pkg::KEY_DOWN]   = btn[ptke_pkg::BTN_DOWN];
      keys_now[ptke_pkg::KEY_ESCAPE] = btn[ptke_pkg::BTN_B];
      keys_now[ptke_pkg::KEY_ENTER]  = btn[ptke_pkg::BTN_START] && !pause;
      keys_now[ptke_pkg::KEY_PAUSE]  = btn[ptke_pkg::BTN_START] && pause;
   end

   always_comb begin
      mask_new = '0;
      mask_new[ptke_pkg::SLOT_MOTION] = move &&
         (button_held_ff ? req_listener_bits[ptke_pkg::LIS_DRAG]
                         : req_listener_bits[ptke_pkg::LIS_HOVER]);
      mask_new[ptke_pkg::SLOT_BUTTON] = (btn[ptke_pkg::BTN_A] != button_held_ff) &&
                                        req_listener_bits[ptke_pkg::LIS_BUTTON];
      mask_new[NS-1:ptke_pkg::SLOT_KEY0] = req_listener_bits[ptke_pkg::LIS_KEY] ?
                                           (keys_now ^ keys_held_ff) : '0;
   end

   assign limit_x = {ptke_pkg::axis_max(cfg.screen_width), {FRAC_BITS{1'b0}}};
   assign limit_y = {ptke_pkg::axis_max(cfg.screen_height), {FRAC_BITS{1'b0}}};

   ptke_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock    (clock),
      .cmd      (cmd),
      .mag      (mag_x_ff),
      .negative (neg_x_ff),
      .speed    (cfg.pointer_speed),
      .dt       (dt_ff),
      .pos      (pointer_x_ff),
      .limit    (limit_x),
      .next_pos (next_x)
   );

   ptke_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock    (clock),
      .cmd      (cmd),
      .mag      (mag_y_ff),
      .negative (neg_y_ff),
      .speed    (cfg.pointer_speed),
      .dt       (dt_ff),
      .pos      (pointer_y_ff),
      .limit    (limit_y),
      .next_pos (next_y)
   );

   // Pick the lowest pending slot.
   always_comb begin
      sel = 4'(NS - 1);
      for (int i = NS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = 4'(i);
         end
      end
   end

   assign key_sel   = 3'(sel - 4'(ptke_pkg::SLOT_KEY0));
   assign mask_rest = mask_ff & (mask_ff - NS'(1));

   always_comb begin
      ev_key  = 3'd0;
      ev_rel  = 1'b0;
      ev_kind = ptke_pkg::EV_KEY;
      if (sel == 4'(ptke_pkg::SLOT_MOTION)) begin
         ev_kind = drag_ff ? ptke_pkg::EV_DRAG : ptke_pkg::EV_HOVER;
      end else if (sel == 4'(ptke_pkg::SLOT_BUTTON)) begin
         ev_kind = ptke_pkg::EV_BUTTON;
         ev_rel  = button_rel_ff;
      end else begin
         ev_key  = key_sel;
         ev_rel  = !keys_held_ff[key_sel];
      end
   end

   always_comb begin
      pointer_x_in   = pointer_x_ff;
      pointer_y_in   = pointer_y_ff;
      button_held_in = button_held_ff;
      keys_held_in   = keys_held_ff;
      mask_in        = mask_ff;
      if (cmd.capture) begin
         if (req_cmd == ptke_pkg::CMD_WARP) begin
            pointer_x_in = {req_warp_x, {FRAC_BITS{1'b0}}};
            pointer_y_in = {req_warp_y, {FRAC_BITS{1'b0}}};
         end else begin
            button_held_in = btn[ptke_pkg::BTN_A];
            keys_held_in   = keys_now;
            mask_in        = mask_new;
         end
      end
      if (cmd.commit && move_ff) begin
         pointer_x_in = next_x;
         pointer_y_in = next_y;
      end
      if (cmd.emit) begin
         mask_in = mask_rest;
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_x_ff   <= {ptke_pkg::RST_SCREEN_WIDTH[10:1], {FRAC_BITS{1'b0}}};
         pointer_y_ff   <= {ptke_pkg::RST_SCREEN_HEIGHT[10:1], {FRAC_BITS{1'b0}}};
         button_held_ff <= 1'b0;
         keys_held_ff   <= '0;
         mask_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pointer_x_ff   <= pointer_x_in;
         pointer_y_ff   <= pointer_y_in;
         button_held_ff <= button_held_in;
         keys_held_ff   <= keys_held_in;
         mask_ff        <= mask_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         drag_ff       <= button_held_ff;
         button_rel_ff <= !btn[ptke_pkg::BTN_A];
         move_ff       <= move;
         mag_x_ff      <= live_x ? abs_x : 8'd0;
         mag_y_ff      <= live_y ? abs_y : 8'd0;
         neg_x_ff      <= req_stick_x[7];
         neg_y_ff      <= req_stick_y[7];
         dt_ff         <= dt;
      end
      if (cmd.emit) begin
         rsp_kind_ff <= ev_kind;
         rsp_key_ff  <= ev_key;
         rsp_rel_ff  <= ev_rel;
         rsp_col_ff  <= pointer_x_ff[PSW-1:FRAC_BITS];
         rsp_row_ff  <= pointer_y_ff[PSW-1:FRAC_BITS];
         rsp_last_ff <= (mask_rest == '0);
      end
   end

   assign status.pending    = |mask_ff;
   assign status.last_event = (mask_rest == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_key_index      = rsp_key_ff;
   assign rsp_released       = rsp_rel_ff;
   assign rsp_pointer_column = rsp_col_ff;
   assign rsp_pointer_row    = rsp_row_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ===== rtl/ptke_ctrl.sv =====
`timescale 1ns / 1ps

module ptke_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_cmd,
   output logic                      req_stall,
   input  ptke_pkg::ctrl_status_type status,
   output ptke_pkg::ctrl_cmd_type    cmd
);

   ptke_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptke_pkg::ST_IDLE: begin
            if (req_valid && req_cmd == ptke_pkg::CMD_POLL) begin
               state_in = ptke_pkg::ST_MUL_SPEED;
            end
         end
         ptke_pkg::ST_MUL_SPEED: state_in = ptke_pkg::ST_MUL_TIME;
         ptke_pkg::ST_MUL_TIME:  state_in = ptke_pkg::ST_MUL_RECIP;
         ptke_pkg::ST_MUL_RECIP: state_in = ptke_pkg::ST_COMMIT;
         ptke_pkg::ST_COMMIT: begin
            state_in = status.pending ? ptke_pkg::ST_EMIT : ptke_pkg::ST_IDLE;
         end
         ptke_pkg::ST_EMIT: begin
            if (status.out_free && status.last_event) begin
               state_in = ptke_pkg::ST_IDLE;
            end
         end
         default: state_in = ptke_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ptke_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ptke_pkg::ST_MUL_SPEED: cmd.stage_speed = 1'b1;
         ptke_pkg::ST_MUL_TIME:  cmd.stage_time  = 1'b1;
         ptke_pkg::ST_MUL_RECIP: cmd.stage_recip = 1'b1;
         ptke_pkg::ST_COMMIT:    cmd.commit      = 1'b1;
         ptke_pkg::ST_EMIT:      cmd.emit        = status.out_free && status.pending;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptke_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/pad_to_pointer_and_key_events_top.sv =====
// Warp item: taken while idle, the next item may follow at once, no transfer out.
// Poll item: after acceptance it passes the speed, time and reciprocal multiply stages
// and the pointer commit; each pending event is then loaded into the output register
// whenever the result side does not stall, and the next item is taken once the last
// event is loaded (at once after the commit when there are none).
// Synchronous reset: registers to defaults, pointer to screen center, states cleared.
`timescale 1ns / 1ps

module pad_to_pointer_and_key_events_top #(
   parameter int POINTER_FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic              req_pad_present,
   input  logic [6:0]        req_button_bits,
   input  logic signed [7:0] req_stick_x,
   input  logic signed [7:0] req_stick_y,
   input  logic [7:0]        req_left_trigger,
   input  logic [15:0]       req_elapsed_ms,
   input  logic [3:0]        req_listener_bits,
   input  logic [9:0]        req_warp_x,
   input  logic [9:0]        req_warp_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_event_kind,
   output logic [2:0]        rsp_key_index,
   output logic              rsp_released,
   output logic [9:0]        rsp_pointer_column,
   output logic [9:0]        rsp_pointer_row,
   output logic              rsp_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   ptke_pkg::cfg_type         cfg;
   ptke_pkg::ctrl_cmd_type    cmd;
   ptke_pkg::ctrl_status_type status;

   ptke_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ptke_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ptke_dp #(.FRAC_BITS(POINTER_FRAC_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_cmd            (req_cmd),
      .req_pad_present    (req_pad_present),
      .req_button_bits    (req_button_bits),
      .req_stick_x        (req_stick_x),
      .req_stick_y        (req_stick_y),
      .req_left_trigger   (req_left_trigger),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_listener_bits  (req_listener_bits),
      .req_warp_x         (req_warp_x),
      .req_warp_y         (req_warp_y),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_key_index      (rsp_key_index),
      .rsp_released       (rsp_released),
      .rsp_pointer_column (rsp_pointer_column),
      .rsp_pointer_row    (rsp_pointer_row),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== rtl/ptke_checker.sv =====
`timescale 1ns / 1ps
`include "pad_to_pointer_and_key_events_top_macros.svh"

module ptke_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_cmd,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_event_kind,
   input logic [2:0]        rsp_key_index,
   input logic              rsp_released,
   input logic [9:0]        rsp_pointer_column,
   input logic              rsp_last
);

   `PTKE_ASSERT_NEXT(a_busy_after_poll, req_valid && !req_stall && req_cmd == ptke_pkg::CMD_POLL, req_stall, "poll transfer not followed by busy")
   `PTKE_ASSERT_NEXT(a_free_after_warp, req_valid && !req_stall && req_cmd == ptke_pkg::CMD_WARP, !req_stall, "warp transfer left the input stalled")
   `PTKE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_kind) && $stable(rsp_key_index) && $stable(rsp_pointer_column) && $stable(rsp_last), "stalled result changed")
   `PTKE_ASSERT_NOW(a_key_index_zero, rsp_valid && rsp_event_kind != ptke_pkg::EV_KEY, rsp_key_index == 3'd0, "non-key event carries a key index")
   `PTKE_ASSERT_NOW(a_motion_press, rsp_valid && (rsp_event_kind == ptke_pkg::EV_DRAG || rsp_event_kind == ptke_pkg::EV_HOVER), !rsp_released, "motion event marked released")

endmodule

bind pad_to_pointer_and_key_events_top ptke_checker u_ptke_checker (.*);
